[rtl/core/stream_find_replace_macros.svh]
// Assertion macros shared by the checker of the find-and-replace block.
// Each macro expands to one labeled concurrent assertion on the rising clock edge.
`ifndef STREAM_FIND_REPLACE_MACROS_SVH
`define STREAM_FIND_REPLACE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SFR_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("find-replace check failed");

// The consequent must hold in the cycle after the antecedent.
`define SFR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("find-replace check failed");

`endif

[rtl/core/sfr_pkg.sv]
// Shared types and constants of the streaming find-and-replace block.
// No dependencies; every other RTL file but the macro header imports this package.
package sfr_pkg;

    localparam int BYTE_W     = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_LEN_W  = 4;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN_BYTES      = 2'd0,
        CFG_PATTERN_LENGTH     = 2'd1,
        CFG_REPLACEMENT_BYTES  = 2'd2,
        CFG_REPLACEMENT_LENGTH = 2'd3
    } t_cfg_idx;

    // Sequencer states, one-hot.
    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SCAN  = 4'b0010,
        ST_REPL  = 4'b0100,
        ST_DRAIN = 4'b1000
    } t_state;

    // Control from the sequencer to the row of window cells.
    typedef struct packed {
        logic load;
        logic shift;
    } t_win_ctrl;

endpackage

[rtl/core/sfr_cell.sv]
// One window cell: holds one text byte and compares it with its pattern byte.
// Depends on sfr_pkg.
module sfr_cell (
    input  logic                       i_clk,
    input  logic                       i_load,
    input  logic                       i_shift,
    input  logic [sfr_pkg::BYTE_W-1:0] i_new_byte,
    input  logic [sfr_pkg::BYTE_W-1:0] i_neighbor,
    input  logic [sfr_pkg::BYTE_W-1:0] i_pat_byte,
    output logic [sfr_pkg::BYTE_W-1:0] o_byte,
    output logic                       o_eq_cur,
    output logic                       o_eq_nxt
);
    import sfr_pkg::*;

    logic [BYTE_W-1:0] r_byte;
    logic [BYTE_W-1:0] n_byte;

    // A new byte lands here, or the byte of the right-hand neighbor moves in.
    always_comb begin
        n_byte = r_byte;
        if (i_load) begin
            n_byte = i_new_byte;
        end else if (i_shift) begin
            n_byte = i_neighbor;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
    end

    // Compare the current byte, and the byte that a shift would bring in.
    assign o_byte   = r_byte;
    assign o_eq_cur = (r_byte == i_pat_byte);
    assign o_eq_nxt = (i_neighbor == i_pat_byte);

endmodule

[rtl/core/sfr_window.sv]
// Row of window cells holding the unsent text, front byte in cell zero.
// Depends on sfr_pkg and sfr_cell.
module sfr_window #(
    parameter int CELLS = 8,
    parameter int LW    = 4
) (
    input  logic                              i_clk,
    input  sfr_pkg::t_win_ctrl                i_ctrl,
    input  logic [LW-1:0]                     i_load_pos,
    input  logic [sfr_pkg::BYTE_W-1:0]        i_new_byte,
    input  logic [CELLS*sfr_pkg::BYTE_W-1:0]  i_pattern,
    output logic [sfr_pkg::BYTE_W-1:0]        o_front,
    output logic [CELLS-1:0]                  o_eq_cur,
    output logic [CELLS-1:0]                  o_eq_nxt
);
    import sfr_pkg::*;

    logic [BYTE_W-1:0] cell_byte [CELLS];
    logic [BYTE_W-1:0] neighbor  [CELLS];

    // Each cell takes the new byte when it is the first free one, and shifts left.
    for (genvar j = 0; j < CELLS; j++) begin : g_cell
        if (j == CELLS - 1) begin : g_end
            assign neighbor[j] = '0;
        end else begin : g_mid
            assign neighbor[j] = cell_byte[j+1];
        end

        sfr_cell u_cell (
            .i_clk      (i_clk),
            .i_load     (i_ctrl.load && (i_load_pos == LW'(j))),
            .i_shift    (i_ctrl.shift),
            .i_new_byte (i_new_byte),
            .i_neighbor (neighbor[j]),
            .i_pat_byte (i_pattern[j*BYTE_W +: BYTE_W]),
            .o_byte     (cell_byte[j]),
            .o_eq_cur   (o_eq_cur[j]),
            .o_eq_nxt   (o_eq_nxt[j])
        );
    end

    assign o_front = cell_byte[0];

endmodule

[rtl/core/stream_find_replace.sv]
// Streaming find-and-replace, top level.
// Depends on sfr_pkg, sfr_window and sfr_cell.
//
// Usage:
//   Configuration writes arrive on the cfg channel (valid/ready, ready is
//   always high) and must only be issued while the block is idle.
//   Input transactions carry one text byte or a flush marker; each output
//   transaction carries one byte of the rewritten text, with o_run_last
//   marking the final result caused by an input.
//   A text byte moves the sequencer from idle to the scan state, and the
//   first released byte is then registered in the output register; a
//   replacement goes from scan to the replacement state, a flush of held
//   bytes to the drain state. A held byte, a deleted match and a flush with
//   nothing held release no output bytes.
//   The window sequencer handles one input at a time, emitting one byte per
//   cycle while not stalled, from the cell row front or the replacement text.
//   When the receiver stalls, the output register holds its transaction and
//   the sequencer waits; input is stalled until the current input is done.
//   Reset clears the configuration, the held count and the output valid flag.
//   Held window bytes are not cleared; they are never read before written.
module stream_find_replace #(
    parameter int PATTERN_MAX = 8,
    parameter int REPLACE_MAX = 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [sfr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [sfr_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [sfr_pkg::BYTE_W-1:0]     i_text_byte,
    input  logic                           i_flush,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [sfr_pkg::BYTE_W-1:0]     o_out_byte,
    output logic                           o_run_last
);
    import sfr_pkg::*;

    localparam int LW  = $clog2(PATTERN_MAX + 1);
    localparam int RLW = $clog2(REPLACE_MAX + 1);
    localparam int RIW = (REPLACE_MAX > 1) ? $clog2(REPLACE_MAX) : 1;
    localparam int PW  = PATTERN_MAX * BYTE_W;
    localparam int RW  = REPLACE_MAX * BYTE_W;

    // Configuration registers, lengths stored already clamped.
    logic [PW-1:0]  r_pat;
    logic [LW-1:0]  r_plen;
    logic [RW-1:0]  r_repl;
    logic [RLW-1:0] r_rlen;

    // Sequencer and output registers.
    t_state          r_state, n_state;
    logic [LW-1:0]   r_len, n_len;
    logic            r_first, n_first;
    logic [RIW-1:0]  r_ridx, n_ridx;
    logic            r_out_valid;
    logic [BYTE_W-1:0] r_out_byte;
    logic            r_out_last;

    t_win_ctrl         win_ctrl;
    logic [BYTE_W-1:0] front;
    logic [PATTERN_MAX-1:0] eq_cur;
    logic [PATTERN_MAX-1:0] eq_nxt;

    logic              accept;
    logic              can_emit;
    logic              pre_cur;
    logic              pre_nxt;
    logic              full_match;
    logic              hold;
    logic              emit;
    logic [BYTE_W-1:0] emit_byte;
    logic              emit_last;
    logic [BYTE_W-1:0] repl_byte;

    // Configuration writes are always taken.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat  <= '0;
            r_plen <= '0;
            r_repl <= '0;
            r_rlen <= '0;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_PATTERN_BYTES: begin
                    r_pat <= i_cfg_data[PW-1:0];
                end
                CFG_PATTERN_LENGTH: begin
                    r_plen <= (i_cfg_data[CFG_LEN_W-1:0] > CFG_LEN_W'(PATTERN_MAX))
                              ? LW'(PATTERN_MAX) : i_cfg_data[LW-1:0];
                end
                CFG_REPLACEMENT_BYTES: begin
                    r_repl <= i_cfg_data[RW-1:0];
                end
                CFG_REPLACEMENT_LENGTH: begin
                    r_rlen <= (i_cfg_data[CFG_LEN_W-1:0] > CFG_LEN_W'(REPLACE_MAX))
                              ? RLW'(REPLACE_MAX) : i_cfg_data[RLW-1:0];
                end
            endcase
        end
    end

    // Window of held bytes plus the newest byte.
    sfr_window #(
        .CELLS (PATTERN_MAX),
        .LW    (LW)
    ) u_window (
        .i_clk      (i_clk),
        .i_ctrl     (win_ctrl),
        .i_load_pos (r_len),
        .i_new_byte (i_text_byte),
        .i_pattern  (r_pat),
        .o_front    (front),
        .o_eq_cur   (eq_cur),
        .o_eq_nxt   (eq_nxt)
    );

    // Prefix checks of the window now and after one front byte drops out.
    always_comb begin
        pre_cur = 1'b1;
        pre_nxt = 1'b1;
        for (int j = 0; j < PATTERN_MAX; j++) begin
            if (j < int'(r_len) && !eq_cur[j]) begin
                pre_cur = 1'b0;
            end
            if (j + 1 < int'(r_len) && !eq_nxt[j]) begin
                pre_nxt = 1'b0;
            end
        end
    end

    assign accept     = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != ST_IDLE);
    assign can_emit   = !r_out_valid || !i_out_stall;
    assign full_match = r_first && (r_len == r_plen) && pre_cur;
    assign hold       = (r_len < r_plen) && pre_cur;
    assign repl_byte  = r_repl[{r_ridx, 3'b000} +: BYTE_W];

    // Sequencer: load, scan the window, emit replacement or drain on flush.
    always_comb begin
        n_state   = r_state;
        n_len     = r_len;
        n_first   = r_first;
        n_ridx    = r_ridx;
        win_ctrl  = '0;
        emit      = 1'b0;
        emit_byte = front;
        emit_last = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_flush) begin
                        n_state = (r_len == '0) ? ST_IDLE : ST_DRAIN;
                    end else begin
                        win_ctrl.load = 1'b1;
                        n_len         = r_len + LW'(1);
                        n_first       = 1'b1;
                        n_state       = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                priority if (full_match) begin
                    n_len   = '0;
                    n_ridx  = '0;
                    n_state = (r_rlen == '0) ? ST_IDLE : ST_REPL;
                end else if (hold) begin
                    n_state = ST_IDLE;
                end else if (can_emit) begin
                    emit           = 1'b1;
                    emit_last      = (r_len == LW'(1)) ||
                                     (((r_len - LW'(1)) < r_plen) && pre_nxt);
                    win_ctrl.shift = 1'b1;
                    n_len          = r_len - LW'(1);
                    n_first        = 1'b0;
                    if (emit_last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_REPL: begin
                if (can_emit) begin
                    emit      = 1'b1;
                    emit_byte = repl_byte;
                    emit_last = (RLW'(r_ridx) == (r_rlen - RLW'(1)));
                    n_ridx    = r_ridx + RIW'(1);
                    if (emit_last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_DRAIN: begin
                if (can_emit) begin
                    emit           = 1'b1;
                    emit_last      = (r_len == LW'(1));
                    win_ctrl.shift = 1'b1;
                    n_len          = r_len - LW'(1);
                    if (emit_last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_len   <= '0;
            r_first <= 1'b0;
            r_ridx  <= '0;
        end else begin
            r_state <= n_state;
            r_len   <= n_len;
            r_first <= n_first;
            r_ridx  <= n_ridx;
        end
    end

    // Output register: holds a transaction until the receiver takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_byte <= emit_byte;
            r_out_last <= emit_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_run_last  = r_out_last;

endmodule

[rtl/core/sfr_checker.sv]
// Port-level checks of the find-and-replace block, bound to its top level.
// Depends on sfr_pkg and stream_find_replace_macros.svh.
`include "stream_find_replace_macros.svh"

module sfr_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       o_in_stall,
    input logic                       i_flush,
    input logic                       o_out_valid,
    input logic                       i_out_stall,
    input logic [sfr_pkg::BYTE_W-1:0] o_out_byte,
    input logic                       o_run_last
);
    import sfr_pkg::*;

    // A stalled output transaction keeps its payload.
    `SFR_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall,
        o_out_valid && $stable(o_out_byte) && $stable(o_run_last))

    // While results of an input are still pending, no new input is taken.
    `SFR_ASSERT_NOW(a_busy_stall, o_out_valid && !o_run_last, o_in_stall)

    // A text byte always takes the window sequencer through at least one scan.
    `SFR_ASSERT_NEXT(a_byte_busy, i_in_valid && !o_in_stall && !i_flush, o_in_stall)

endmodule

bind stream_find_replace sfr_checker u_sfr_checker (.*);

[verif/rewrite_check_pkg.sv]
// Scoreboard for the streaming find-and-replace testbench: rewrite predictor and result check.
// Depends on sfr_pkg for the configuration register indexes.
package rewrite_check_pkg;
    import sfr_pkg::*;

    // One expected byte of rewritten text.
    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_rewrite_byte;

    class rewrite_scoreboard;
        logic [63:0]   pat_word;
        logic [3:0]    pat_len;
        logic [63:0]   rep_word;
        logic [3:0]    rep_len;
        logic [7:0]    held [7];
        int unsigned   held_cnt;
        logic [7:0]    window [8];
        t_rewrite_byte pending_bytes [$];
        int unsigned   mismatches;

        function new();
            pat_word   = '0;
            pat_len    = '0;
            rep_word   = '0;
            rep_len    = '0;
            held_cnt   = 0;
            mismatches = 0;
            foreach (held[i]) held[i] = '0;
        endfunction

        // Mirror of a configuration write.
        function void set_reg(t_cfg_idx idx, logic [63:0] data);
            case (idx)
                CFG_PATTERN_BYTES:      pat_word = data;
                CFG_PATTERN_LENGTH:     pat_len  = data[3:0];
                CFG_REPLACEMENT_BYTES:  rep_word = data;
                CFG_REPLACEMENT_LENGTH: rep_len  = data[3:0];
                default: ;
            endcase
        endfunction

        // True when the window bytes from start on match the pattern's first len bytes.
        function bit window_fits(int unsigned start, int unsigned len);
            for (int unsigned i = 0; i < len; i++) begin
                if (window[(start + i) & 7] != pat_word[i*8 +: 8]) return 1'b0;
            end
            return 1'b1;
        endfunction

        // Work out the bytes that one accepted transaction releases.
        function void note_input(logic [7:0] text, logic flush);
            logic [7:0]    emitted [$];
            int unsigned   w;
            int unsigned   plen;
            int unsigned   rlen;
            int unsigned   start;
            int unsigned   len;
            int unsigned   keep;
            bit            matched;
            t_rewrite_byte item;

            matched = 1'b0;
            if (flush) begin
                for (int unsigned i = 0; i < held_cnt; i++) emitted = {emitted, held[i]};
                held_cnt = 0;
            end else begin
                for (int unsigned i = 0; i < held_cnt; i++) window[i] = held[i];
                window[held_cnt] = text;
                w     = held_cnt + 1;
                plen  = (pat_len > 8) ? 8 : pat_len;
                start = 0;
                if (plen == 0) begin
                    for (int unsigned i = 0; i < w; i++) emitted = {emitted, window[i]};
                    start = w;
                end else begin
                    // Drop front bytes until the rest is a proper prefix or the whole
                    // window is the pattern.
                    while (start < w) begin
                        len = w - start;
                        if (start == 0 && len == plen && window_fits(0, len)) begin
                            rlen = (rep_len > 8) ? 8 : rep_len;
                            for (int unsigned i = 0; i < rlen; i++) begin
                                emitted = {emitted, rep_word[i*8 +: 8]};
                            end
                            matched = 1'b1;
                            break;
                        end
                        if (len < plen && window_fits(start, len)) break;
                        emitted = {emitted, window[start]};
                        start++;
                    end
                end
                if (matched) begin
                    held_cnt = 0;
                end else begin
                    keep = w - start;
                    if (keep > 7) keep = 7;
                    for (int unsigned i = 0; i < keep; i++) held[i] = window[(start + i) & 7];
                    held_cnt = keep;
                end
            end

            // The final byte of the run carries the last flag.
            for (int i = 0; i < emitted.size(); i++) begin
                item.data     = emitted[i];
                item.last     = (i == emitted.size() - 1);
                pending_bytes = {pending_bytes, item};
            end
        endfunction

        task report(string msg);
            $display("MISMATCH: %s", msg);
            mismatches++;
        endtask

        // Compare one output transaction with the oldest expected byte.
        task check_byte(logic [7:0] data, logic last);
            t_rewrite_byte want;
            if (pending_bytes.size() == 0) begin
                report($sformatf("output byte %02h with nothing expected", data));
                return;
            end
            want = pending_bytes.pop_front();
            if (data !== want.data) begin
                report($sformatf("out_byte %02h, expected %02h", data, want.data));
            end
            if (last !== want.last) begin
                report($sformatf("run_last %b, expected %b (byte %02h)", last, want.last,
                                 want.data));
            end
        endtask
    endclass

endpackage

[verif/tb_top.sv]
// Top-level testbench of the streaming find-and-replace block.
// Depends on sfr_pkg, rewrite_check_pkg and the RTL of stream_find_replace.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import sfr_pkg::*;
    import rewrite_check_pkg::*;

    localparam int unsigned SETTLE_CYCLES   = 12;
    localparam int unsigned WATCHDOG_LIMIT  = 5000;
    localparam int unsigned ITEMS_PER_PHASE = 38;
    localparam int unsigned NUM_PHASES      = 8;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic [BYTE_W-1:0]     i_text_byte;
    logic                  i_flush;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic [BYTE_W-1:0]     o_out_byte;
    logic                  o_run_last;

    rewrite_scoreboard sb;
    int unsigned       send_idle_pct = 0;
    int unsigned       stall_pct     = 0;
    int unsigned       quiet_cycles  = 0;

    stream_find_replace u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_text_byte (i_text_byte),
        .i_flush     (i_flush),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_byte  (o_out_byte),
        .o_run_last  (o_run_last)
    );

    // 10 ns clock.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Receiver backpressure, changed on the falling edge.
    always @(negedge i_clk) begin
        i_out_stall = (stall_pct != 0) && ($urandom_range(99) < stall_pct);
    end

    // Every accepted output transaction goes to the scoreboard.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            sb.check_byte(o_out_byte, o_run_last);
        end
    end

    // Watchdog: ends the run after a long stretch with no transaction on any channel.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Send one input transaction, with random idle cycles ahead of it.
    task automatic send_item(input logic [7:0] text, input logic flush);
        @(negedge i_clk);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid  = 1'b1;
        i_text_byte = text;
        i_flush     = flush;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_input(text, flush);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
    endtask

    // Wait until every expected byte has arrived and the block has gone quiet.
    task automatic settle();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (sb.pending_bytes.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [63:0] data);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.set_reg(idx, data);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // Length word with random bits above the four that count.
    function automatic logic [63:0] len_word(input int unsigned len);
        logic [63:0] v;
        v      = {$urandom, $urandom};
        v[3:0] = len[3:0];
        return v;
    endfunction

    // Pack a string into a byte word, first byte low; unused bytes are random.
    function automatic logic [63:0] pack_text(input string s);
        logic [63:0] v;
        v = {$urandom, $urandom};
        for (int i = 0; i < s.len() && i < 8; i++) v[i*8 +: 8] = s[i];
        return v;
    endfunction

    // Reprogram all four registers once the block is idle.
    task automatic load_rules(input logic [63:0] pat, input int unsigned plen,
                              input logic [63:0] rep, input int unsigned rlen);
        settle();
        write_reg(CFG_PATTERN_BYTES, pat);
        write_reg(CFG_PATTERN_LENGTH, len_word(plen));
        write_reg(CFG_REPLACEMENT_BYTES, rep);
        write_reg(CFG_REPLACEMENT_LENGTH, len_word(rlen));
    endtask

    initial begin
        int unsigned send_idle_tab [4] = '{0, 84, 0, 23};
        int unsigned stall_tab [4]     = '{0, 0, 84, 23};
        int unsigned plen_tab [NUM_PHASES] = '{1, 8, 15, 3, 0, 2, 5, 9};
        int unsigned rlen_tab [NUM_PHASES] = '{8, 0, 12, 1, 3, 15, 0, 2};
        logic [7:0]  alpha [3];
        logic [63:0] pat;
        int unsigned peff;
        int unsigned sent;
        int unsigned pick;
        int unsigned k;

        sb          = new();
        i_rst_n     = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        i_in_valid  = 1'b0;
        i_text_byte = '0;
        i_flush     = 1'b0;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Pass-through after reset, byte extremes, and a flush with nothing held.
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(8'($urandom), 1'b1);

        // A match, a partial match that falls apart, and a flush of held bytes.
        load_rules(pack_text("abc"), 3, pack_text("XY"), 2);
        send_text("abc");
        send_text("abx");
        send_text("ab");
        send_item(8'($urandom), 1'b1);

        // Held bytes come out ahead of the next byte after a switch to pass-through.
        send_text("ab");
        load_rules(pack_text("abc"), 0, pack_text("XY"), 2);
        send_text("q");

        // An empty replacement deletes the match.
        load_rules(pack_text("abc"), 3, pack_text("XY"), 0);
        send_text("abc");

        // New pattern while bytes are held: the front byte drops, then the rest matches.
        send_text("ab");
        load_rules(pack_text("bcd"), 3, pack_text("Z"), 1);
        send_text("cd");

        // Random phases: each idling mode with two rule sets. Most traffic is built from
        // the pattern so that matches and partial matches are frequent.
        for (int p = 0; p < NUM_PHASES; p++) begin
            foreach (alpha[i]) alpha[i] = 8'($urandom);
            peff = (plen_tab[p] > 8) ? 8 : plen_tab[p];
            pat  = {$urandom, $urandom};
            for (int i = 0; i < peff; i++) pat[i*8 +: 8] = alpha[$urandom_range(2)];
            load_rules(pat, plen_tab[p], {$urandom, $urandom}, rlen_tab[p]);
            send_idle_pct = send_idle_tab[p / 2];
            stall_pct     = stall_tab[p / 2];

            sent = 0;
            while (sent < ITEMS_PER_PHASE) begin
                pick = $urandom_range(99);
                if (peff == 0 || pick < 10) begin
                    send_item(8'($urandom), 1'b0);
                    sent++;
                end else if (pick < 45) begin
                    for (int i = 0; i < peff; i++) send_item(pat[i*8 +: 8], 1'b0);
                    sent += peff;
                end else if (pick < 65) begin
                    k = $urandom_range(peff - 1);
                    for (int i = 0; i < k; i++) send_item(pat[i*8 +: 8], 1'b0);
                    send_item(alpha[$urandom_range(2)], 1'b0);
                    sent += k + 1;
                end else if (pick < 93) begin
                    send_item(alpha[$urandom_range(2)], 1'b0);
                    sent++;
                end else begin
                    send_item(8'($urandom), 1'b1);
                    sent++;
                end
            end
        end

        // Release whatever is still held, then drain.
        send_item(8'($urandom), 1'b1);
        settle();

        if (sb.mismatches == 0 && sb.pending_bytes.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

[files.f]
+incdir+rtl/core
rtl/core/sfr_pkg.sv
rtl/core/sfr_cell.sv
rtl/core/sfr_window.sv
rtl/core/stream_find_replace.sv
rtl/core/sfr_checker.sv
verif/rewrite_check_pkg.sv
verif/tb_top.sv
